>>> design/assert_macros.svh
// Assertion macros for the SHA-1 hasher RTL.
// No dependencies; included by sha1_message_hasher_core, the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/sha1mh_pkg.sv
// Types, constants and helpers for the SHA-1 message hasher.
// No dependencies; imported by every module of the block.
package sha1mh_pkg;

   localparam int WORD_W      = 32;
   localparam int NUM_HASH    = 5;
   localparam int BLOCK_BITS  = 512;

   typedef logic [WORD_W-1:0]         word_type;
   typedef logic [NUM_HASH-1:0][WORD_W-1:0] hash_arr_type;
   typedef logic [6:0]                round_idx_type;
   typedef logic [7:0]                byte_type;

   localparam hash_arr_type HASH_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                         32'hEFCDAB89, 32'h67452301};

   localparam word_type K_R0 = 32'h5A827999;
   localparam word_type K_R1 = 32'h6ED9EBA1;
   localparam word_type K_R2 = 32'h8F1BBCDC;
   localparam word_type K_R3 = 32'hCA62C1D6;

   localparam round_idx_type ROUND_B1   = 7'd20;
   localparam round_idx_type ROUND_B2   = 7'd40;
   localparam round_idx_type ROUND_B3   = 7'd60;
   localparam round_idx_type LAST_ROUND = 7'd79;

   localparam byte_type   PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_START_POS = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   typedef struct packed {
      logic          init;
      logic          load;
      logic          step;
      logic          update;
      round_idx_type round_idx;
   } rnd_ctrl_type;

   typedef struct packed {
      logic     push;
      byte_type data;
      logic     step;
   } sch_ctrl_type;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

endpackage

>>> design/sha1_message_hasher_core.sv
// SHA-1 message hasher top level: byte intake, padding sequencer, digest output.
// Depends on sha1mh_pkg, sha1mh_sched, sha1mh_round and assert_macros.svh.
// A byte item is taken while idle; one that fills a block starts compression and the update.
// Intake stalls while a block is compressed, so no new byte is taken until that block is done.
// A last item runs the pad bytes and each padded block, then the five digest words, each held until taken.
// Reset (synchronous): chaining words to the initial values, bit count zero, idle.
`include "assert_macros.svh"

module sha1_message_hasher_core import sha1mh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_COMPRESS, ST_UPDATE, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PAD_MARK, PAD_ZERO, PAD_LEN
   } pad_sel_type;

   state_type     state_ff,     state_in;
   pad_sel_type   pad_sel_ff,   pad_sel_in;
   logic [63:0]   count_ff,     count_in;
   logic [5:0]    pos_ff,       pos_in;
   logic [2:0]    len_idx_ff,   len_idx_in;
   logic [2:0]    word_idx_ff,  word_idx_in;
   round_idx_type round_ff,     round_in;
   logic          finishing_ff, finishing_in;
   logic          pad_done_ff,  pad_done_in;

   logic          req_fire;
   logic          rsp_fire;
   byte_type      pad_byte;
   hash_arr_type  hash_words;
   word_type      w_cur;
   rnd_ctrl_type  rnd_ctrl;
   sch_ctrl_type  sch_ctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   always_comb begin
      unique case (pad_sel_ff)
         PAD_MARK: pad_byte = PAD_MARK_BYTE;
         PAD_ZERO: pad_byte = '0;
         PAD_LEN:  pad_byte = 8'(count_ff >> {len_idx_ff, 3'b000});
         default:  pad_byte = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pad_sel_in   = pad_sel_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      len_idx_in   = len_idx_ff;
      word_idx_in  = word_idx_ff;
      round_in     = round_ff;
      finishing_in = finishing_ff;
      pad_done_in  = pad_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               finishing_in = req_last;
               pad_sel_in   = PAD_MARK;
               if (req_has_byte) begin
                  pos_in   = pos_ff + 6'd1;
                  count_in = count_ff + 64'd8;
               end
               if (req_has_byte && pos_ff == LAST_POS) begin
                  state_in = ST_COMPRESS;
                  round_in = '0;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            pos_in = pos_ff + 6'd1;
            if (pad_sel_ff == PAD_LEN) begin
               len_idx_in = len_idx_ff - 3'd1;
               if (len_idx_ff == 3'd0) begin
                  pad_done_in = 1'b1;
               end
            end else if (pos_ff + 6'd1 == LEN_START_POS) begin
               pad_sel_in = PAD_LEN;
               len_idx_in = 3'd7;
            end else begin
               pad_sel_in = PAD_ZERO;
            end
            if (pos_ff == LAST_POS) begin
               state_in = ST_COMPRESS;
               round_in = '0;
            end
         end
         ST_COMPRESS: begin
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (pad_done_ff) begin
               state_in    = ST_EMIT;
               word_idx_in = '0;
            end else if (finishing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               word_idx_in = word_idx_ff + 3'd1;
               if (word_idx_ff == LAST_WORD_IDX) begin
                  state_in     = ST_IDLE;
                  count_in     = '0;
                  pos_in       = '0;
                  finishing_in = 1'b0;
                  pad_done_in  = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_sel_ff   <= PAD_MARK;
         count_ff     <= '0;
         pos_ff       <= '0;
         len_idx_ff   <= '0;
         word_idx_ff  <= '0;
         round_ff     <= '0;
         finishing_ff <= 1'b0;
         pad_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_sel_ff   <= pad_sel_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         len_idx_ff   <= len_idx_in;
         word_idx_ff  <= word_idx_in;
         round_ff     <= round_in;
         finishing_ff <= finishing_in;
         pad_done_ff  <= pad_done_in;
      end
   end

   always_comb begin
      rnd_ctrl.init      = rsp_fire && (word_idx_ff == LAST_WORD_IDX);
      rnd_ctrl.load      = (state_in == ST_COMPRESS) && (state_ff != ST_COMPRESS);
      rnd_ctrl.step      = (state_ff == ST_COMPRESS);
      rnd_ctrl.update    = (state_ff == ST_UPDATE);
      rnd_ctrl.round_idx = round_ff;
      sch_ctrl.push      = (req_fire && req_has_byte) || (state_ff == ST_PAD);
      sch_ctrl.data      = (state_ff == ST_PAD) ? pad_byte : req_data_byte;
      sch_ctrl.step      = (state_ff == ST_COMPRESS);
   end

   sha1mh_sched u_sched (
      .clock (clock),
      .ctrl  (sch_ctrl),
      .w_out (w_cur)
   );

   sha1mh_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rnd_ctrl),
      .w_in     (w_cur),
      .hash_out (hash_words)
   );

   assign rsp_digest_word = hash_words[word_idx_ff];
   assign rsp_word_index  = word_idx_ff;
   assign rsp_last_word   = (word_idx_ff == LAST_WORD_IDX);

   `ASSERT_NEXT(a_digest_restarts, clock, reset, rsp_fire && rsp_last_word, (count_ff == 64'd0) && !req_stall)
   `ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_COMPRESS, round_ff <= LAST_ROUND)
   `ASSERT_NEXT(a_update_after_last_round, clock, reset, (state_ff == ST_COMPRESS) && (round_ff == LAST_ROUND), state_ff == ST_UPDATE)
   `ASSERT_IMPL(a_len_position, clock, reset, (state_ff == ST_PAD) && (pad_sel_ff == PAD_LEN), pos_ff == {3'b111, ~len_idx_ff})
   `ASSERT_IMPL(a_no_intake_while_emitting, clock, reset, rsp_valid, req_stall)

endmodule

>>> design/sha1mh_sched.sv
// 512-bit block buffer that doubles as the rolling message schedule.
// Depends on sha1mh_pkg.
module sha1mh_sched import sha1mh_pkg::*; (
   input  logic         clock,
   input  sch_ctrl_type ctrl,
   output word_type     w_out
);

   logic [BLOCK_BITS-1:0] sched_ff;
   logic [BLOCK_BITS-1:0] sched_in;
   word_type              w_next;

   // word i sits at sched_ff[511-32i -: 32]; word 0 is the current round's w
   assign w_next = rotl(sched_ff[511-32*13 -: WORD_W] ^ sched_ff[511-32*8 -: WORD_W]
                      ^ sched_ff[511-32*2 -: WORD_W] ^ sched_ff[511 -: WORD_W], 1);
   assign w_out  = sched_ff[511 -: WORD_W];

   always_comb begin
      sched_in = sched_ff;
      if (ctrl.push) begin
         sched_in = {sched_ff[BLOCK_BITS-9:0], ctrl.data};
      end else if (ctrl.step) begin
         sched_in = {sched_ff[BLOCK_BITS-WORD_W-1:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
   end

endmodule

>>> design/sha1mh_round.sv
// Shared SHA-1 round unit: working variables a..e and the chaining words.
// Depends on sha1mh_pkg.
module sha1mh_round import sha1mh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rnd_ctrl_type ctrl,
   input  word_type     w_in,
   output hash_arr_type hash_out
);

   hash_arr_type hash_ff;
   hash_arr_type rv_ff;
   word_type     f_val;
   word_type     k_val;
   word_type     t_val;

   always_comb begin
      priority if (ctrl.round_idx < ROUND_B1) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (~rv_ff[1] & rv_ff[3]);
         k_val = K_R0;
      end else if (ctrl.round_idx < ROUND_B2) begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = K_R1;
      end else if (ctrl.round_idx < ROUND_B3) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (rv_ff[1] & rv_ff[3]) | (rv_ff[2] & rv_ff[3]);
         k_val = K_R2;
      end else begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = K_R3;
      end
      t_val = rotl(rv_ff[0], 5) + f_val + rv_ff[4] + k_val + w_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rv_ff <= hash_ff;
      end else if (ctrl.step) begin
         rv_ff <= {rv_ff[3], rv_ff[2], rotl(rv_ff[1], 30), rv_ff[0], t_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         hash_ff <= HASH_INIT;
      end else if (ctrl.update) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            hash_ff[i] <= hash_ff[i] + rv_ff[i];
         end
      end
   end

   assign hash_out = hash_ff;

endmodule
